FILE: sv/lcd_background_pixel_engine_defines.svh
// Assertion macros used by the checker file.
`ifndef LCD_BACKGROUND_PIXEL_ENGINE_DEFINES_SVH
`define LCD_BACKGROUND_PIXEL_ENGINE_DEFINES_SVH

// Same-cycle implication, skipped while reset is asserted.
`define LBPE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lbpe check failed");

// Next-cycle implication, evaluated during reset too.
`define LBPE_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("lbpe check failed");

`endif

FILE: sv/lbpe_pkg.sv
package lbpe_pkg;

    localparam int VRAM_BYTES      = 8192;
    localparam int VRAM_AW         = 13;
    localparam int DEF_SCREEN_WIDTH = 160;
    localparam int SCREEN_HEIGHT   = 144;
    localparam int LINE_TICKS      = 114;
    localparam int SEARCH_TICKS    = 20;
    localparam int LAST_LINE       = 153;
    localparam int IN_QUEUE_DEPTH  = 4;
    localparam int OUT_QUEUE_DEPTH = 2;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_SEARCH = 2'd2;
    localparam logic [1:0] MODE_XFER   = 2'd3;

    localparam logic [2:0] CFG_LCD_CONTROL  = 3'd0;
    localparam logic [2:0] CFG_SCROLL_Y     = 3'd1;
    localparam logic [2:0] CFG_SCROLL_X     = 3'd2;
    localparam logic [2:0] CFG_LINE_COMPARE = 3'd3;
    localparam logic [2:0] CFG_BG_PALETTE   = 3'd4;

    typedef struct packed {
        logic [1:0]  func;
        logic [12:0] vram_address;
        logic [7:0]  vram_data;
    } t_item_in;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] line;
        logic       line_match;
        logic [2:0] pixel_count;
        logic [7:0] pixel_x;
        logic [1:0] shade_a;
        logic [1:0] shade_b;
        logic [1:0] shade_c;
        logic [1:0] shade_d;
        logic       frame_done;
        logic [7:0] read_data;
    } t_result;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_WRITE,
        OP_READ,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [12:0] addr;
        logic [7:0]  data;
    } t_front_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_MAP,
        ST_TILE,
        ST_HI
    } t_state;

endpackage

FILE: sv/lbpe_fifo.sv
module lbpe_fifo
    import lbpe_pkg::*;
#(
    parameter type T     = t_result,
    parameter int  DEPTH = OUT_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    output logic o_empty,
    input  logic i_pop,
    output T     o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T                r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic            wr_en;
    logic            rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({wr_en, rd_en})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

FILE: sv/lbpe_front.sv
module lbpe_front
    import lbpe_pkg::*;
#(
    parameter int DEPTH = IN_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_item_in    i_item,
    output logic        o_full,
    output logic        o_empty,
    input  logic        i_pop,
    output t_front_item o_item
);
    t_front_item cls;

    always_comb begin
        cls.addr = i_item.vram_address;
        cls.data = i_item.vram_data;
        unique case (i_item.func)
            FUNC_TICK:  cls.op = OP_TICK;
            FUNC_WRITE: cls.op = OP_WRITE;
            FUNC_READ:  cls.op = OP_READ;
            default:    cls.op = OP_NOP;
        endcase
    end

    lbpe_fifo #(.T(t_front_item), .DEPTH(DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cls),
        .o_full  (o_full),
        .o_empty (o_empty),
        .i_pop   (i_pop),
        .o_data  (o_item)
    );

endmodule

FILE: sv/lbpe_back.sv
module lbpe_back
    import lbpe_pkg::*;
#(
    parameter int SCREEN_WIDTH = DEF_SCREEN_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_empty,
    input  t_front_item i_item,
    output logic        o_pop,
    input  logic        i_full,
    output logic        o_push,
    output t_result     o_res
);
    localparam int CW = $clog2(SCREEN_WIDTH + 1);

    logic [7:0] r_ctrl, r_scy, r_scx, r_lyc, r_bgp;

    t_state        r_state, n_state;
    logic [6:0]    r_ticks, n_ticks;
    logic [1:0]    r_mode, n_mode;
    logic [7:0]    r_lc, n_lc;
    logic          r_match, n_match;
    logic          r_phase, n_phase;
    logic [5:0]    r_fcol, n_fcol;
    logic [CW-1:0] r_col, n_col;
    logic          r_fempty, n_fempty;
    logic          r_needs, n_needs;
    logic [15:0]   r_lo, n_lo, r_hi, n_hi, r_msk, n_msk;
    logic [7:0]    r_latlo, n_latlo;
    logic          r_latmsk, n_latmsk;
    logic [12:0]   r_trow, n_trow;
    t_result       r_res, n_res;

    logic [7:0]    r_mem [VRAM_BYTES];
    logic [7:0]    r_rdata;
    logic [VRAM_AW-1:0] rd_addr;
    logic          mem_we;

    logic [7:0]    pix_y;
    logic [4:0]    map_col;
    logic [6:0]    tinc;
    logic [7:0]    lcb;
    logic [CW-1:0] left;
    logic [2:0]    npix;
    logic [1:0]    cidx;
    logic [1:0]    shade [4];
    logic          finish;
    logic          sh8;

    assign pix_y   = r_scy + r_lc - 8'd1;
    assign map_col = r_scx[7:3] + r_fcol[4:0];
    assign tinc    = (r_ticks == 7'h7F) ? r_ticks : r_ticks + 7'd1;
    assign left    = CW'(SCREEN_WIDTH) - r_col;
    assign npix    = (left < CW'(4)) ? left[2:0] : 3'd4;
    assign sh8     = r_fempty;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            cidx     = {r_hi[15-k], r_lo[15-k]};
            shade[k] = (r_msk[15-k] && (3'(k) < npix)) ? r_bgp[2*cidx +: 2] : 2'd0;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_ticks  = r_ticks;
        n_mode   = r_mode;
        n_lc     = r_lc;
        n_match  = r_match;
        n_phase  = r_phase;
        n_fcol   = r_fcol;
        n_col    = r_col;
        n_fempty = r_fempty;
        n_needs  = r_needs;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_msk    = r_msk;
        n_latlo  = r_latlo;
        n_latmsk = r_latmsk;
        n_trow   = r_trow;
        n_res    = r_res;
        o_pop    = 1'b0;
        o_push   = 1'b0;
        rd_addr  = i_item.addr;
        mem_we   = 1'b0;
        finish   = 1'b0;
        lcb      = r_lc;
        o_res    = r_res;

        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty && !i_full) begin
                    o_pop = 1'b1;
                    n_res = '0;
                    unique case (i_item.op)
                        OP_WRITE: begin
                            mem_we = 1'b1;
                            o_push = 1'b1;
                        end
                        OP_READ: begin
                            n_state = ST_RD;
                        end
                        OP_NOP: begin
                            o_push = 1'b1;
                        end
                        OP_TICK: begin
                            n_ticks = tinc;
                            o_push  = (r_mode != MODE_XFER);
                            unique case (r_mode)
                                MODE_HBLANK: begin
                                    if (tinc >= 7'(LINE_TICKS)) begin
                                        n_mode  = (r_lc >= 8'(SCREEN_HEIGHT)) ? MODE_VBLANK
                                                                            : MODE_SEARCH;
                                        n_ticks = '0;
                                        n_match = (r_lc == r_lyc);
                                        n_lc    = r_lc + 8'd1;
                                    end
                                end
                                MODE_VBLANK: begin
                                    if (tinc >= 7'(LINE_TICKS)) begin
                                        if (r_lc >= 8'(LAST_LINE)) begin
                                            n_res.frame_done = 1'b1;
                                            n_mode = MODE_SEARCH;
                                            lcb    = 8'd0;
                                        end
                                        n_ticks = '0;
                                        n_match = (lcb == r_lyc);
                                        n_lc    = lcb + 8'd1;
                                    end
                                end
                                MODE_SEARCH: begin
                                    if (tinc >= 7'(SEARCH_TICKS)) begin
                                        n_mode = MODE_XFER;
                                    end
                                end
                                default: begin
                                    if (!r_needs && (r_col < CW'(SCREEN_WIDTH))) begin
                                        n_res.pixel_count = npix;
                                        n_res.pixel_x     = r_col[7:0];
                                        n_res.shade_a     = shade[0];
                                        n_res.shade_b     = shade[1];
                                        n_res.shade_c     = shade[2];
                                        n_res.shade_d     = shade[3];
                                        n_lo  = r_lo << npix;
                                        n_hi  = r_hi << npix;
                                        n_msk = r_msk << npix;
                                        n_col = r_col + CW'(npix);
                                    end
                                    if (!r_phase) begin
                                        rd_addr = {2'b11, r_ctrl[3], pix_y[7:3], map_col};
                                        n_state = ST_MAP;
                                    end else begin
                                        rd_addr = r_trow + 13'd1;
                                        n_state = ST_HI;
                                    end
                                end
                            endcase
                        end
                        default: o_push = 1'b1;
                    endcase
                    o_res = n_res;
                end
            end
            ST_RD: begin
                o_res.read_data = r_rdata;
                o_push  = 1'b1;
                n_state = ST_IDLE;
            end
            ST_MAP: begin
                // map byte in r_rdata: signed or unsigned tile index
                n_trow  = {~r_ctrl[4] & ~r_rdata[7], r_rdata, pix_y[2:0], 1'b0};
                rd_addr = n_trow;
                n_state = ST_TILE;
            end
            ST_TILE: begin
                n_latlo  = r_rdata;
                n_latmsk = r_ctrl[0];
                n_fcol   = r_fcol + 6'd1;
                n_phase  = 1'b1;
                finish   = 1'b1;
            end
            ST_HI: begin
                if (sh8) begin
                    n_lo     = r_lo | {r_latlo, 8'h00};
                    n_hi     = r_hi | {r_rdata, 8'h00};
                    n_msk    = r_msk | {{8{r_latmsk}}, 8'h00};
                    n_fempty = 1'b0;
                end else begin
                    n_lo    = r_lo | {8'h00, r_latlo};
                    n_hi    = r_hi | {8'h00, r_rdata};
                    n_msk   = r_msk | {8'h00, {8{r_latmsk}}};
                    n_needs = 1'b0;
                end
                n_phase = 1'b0;
                finish  = 1'b1;
            end
            default: n_state = ST_IDLE;
        endcase

        if (finish) begin
            if (r_col >= CW'(SCREEN_WIDTH)) begin
                n_phase  = 1'b0;
                n_fcol   = '0;
                n_col    = '0;
                n_fempty = 1'b1;
                n_needs  = 1'b1;
                n_lo     = '0;
                n_hi     = '0;
                n_msk    = '0;
                n_mode   = MODE_HBLANK;
            end
            o_push  = 1'b1;
            n_state = ST_IDLE;
        end

        o_res.mode       = n_mode;
        o_res.line       = n_lc;
        o_res.line_match = n_match;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl   <= 8'd0;
            r_scy    <= 8'd0;
            r_scx    <= 8'd0;
            r_lyc    <= 8'd0;
            r_bgp    <= 8'd228;
            r_state  <= ST_IDLE;
            r_ticks  <= '0;
            r_mode   <= MODE_SEARCH;
            r_lc     <= 8'd1;
            r_match  <= 1'b0;
            r_phase  <= 1'b0;
            r_fcol   <= '0;
            r_col    <= '0;
            r_fempty <= 1'b1;
            r_needs  <= 1'b1;
            r_lo     <= '0;
            r_hi     <= '0;
            r_msk    <= '0;
            r_latlo  <= '0;
            r_latmsk <= 1'b0;
            r_trow   <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_LCD_CONTROL:  r_ctrl <= i_cfg_data;
                    CFG_SCROLL_Y:     r_scy  <= i_cfg_data;
                    CFG_SCROLL_X:     r_scx  <= i_cfg_data;
                    CFG_LINE_COMPARE: r_lyc  <= i_cfg_data;
                    CFG_BG_PALETTE:   r_bgp  <= i_cfg_data;
                    default: ;
                endcase
            end
            r_state  <= n_state;
            r_ticks  <= n_ticks;
            r_mode   <= n_mode;
            r_lc     <= n_lc;
            r_match  <= n_match;
            r_phase  <= n_phase;
            r_fcol   <= n_fcol;
            r_col    <= n_col;
            r_fempty <= n_fempty;
            r_needs  <= n_needs;
            r_lo     <= n_lo;
            r_hi     <= n_hi;
            r_msk    <= n_msk;
            r_latlo  <= n_latlo;
            r_latmsk <= n_latmsk;
            r_trow   <= n_trow;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_item.addr] <= i_item.data;
        end
        r_rdata <= r_mem[rd_addr];
    end

endmodule

FILE: sv/lcd_background_pixel_engine.sv
// Items pass from the input queue to the execute stage one at a time; a new
// one is taken once the last result is pushed and the output queue has room.
// Writes and idle ticks push at once, reads and second fetch halves after one
// VRAM read, first fetch halves after a map then a tile read (one read port).
// Reset (i_rst_n low, synchronous) empties both queues and restores engine state.
module lcd_background_pixel_engine
    import lbpe_pkg::*;
#(
    parameter int SCREEN_WIDTH = DEF_SCREEN_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       push,
    output logic       full,
    input  t_item_in   i_item,
    output logic       empty,
    input  logic       pop,
    output t_result    o_result
);
    t_front_item fr_item;
    logic        fr_empty;
    logic        fr_pop;
    logic        oq_full;
    logic        oq_push;
    t_result     oq_data;

    lbpe_front #(.DEPTH(IN_QUEUE_DEPTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .o_full  (full),
        .o_empty (fr_empty),
        .i_pop   (fr_pop),
        .o_item  (fr_item)
    );

    lbpe_back #(.SCREEN_WIDTH(SCREEN_WIDTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_empty     (fr_empty),
        .i_item      (fr_item),
        .o_pop       (fr_pop),
        .i_full      (oq_full),
        .o_push      (oq_push),
        .o_res       (oq_data)
    );

    lbpe_fifo #(.T(t_result), .DEPTH(OUT_QUEUE_DEPTH)) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (oq_push),
        .i_data  (oq_data),
        .o_full  (oq_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_data  (o_result)
    );

endmodule

FILE: sv/lbpe_checker.sv
`include "lcd_background_pixel_engine_defines.svh"

module lbpe_checker
    import lbpe_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    full,
    input logic    empty,
    input t_result o_result
);
    `LBPE_ASSERT_NEXT(a_reset_clears, i_clk, !i_rst_n, empty && !full)
    `LBPE_ASSERT_NOW(a_count_range, i_clk, i_rst_n, !empty, o_result.pixel_count <= 3'd4)
    `LBPE_ASSERT_NOW(a_idle_pixels, i_clk, i_rst_n, !empty && o_result.pixel_count == 3'd0, o_result.pixel_x == 8'd0 && o_result.shade_a == 2'd0 && o_result.shade_d == 2'd0)
    `LBPE_ASSERT_NOW(a_read_alone, i_clk, i_rst_n, !empty && o_result.read_data != 8'd0, o_result.pixel_count == 3'd0 && !o_result.frame_done)
    `LBPE_ASSERT_NOW(a_frame_start, i_clk, i_rst_n, !empty && o_result.frame_done, o_result.mode == MODE_SEARCH && o_result.line == 8'd1)

endmodule

bind lcd_background_pixel_engine lbpe_checker u_lbpe_checker (.*);

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import lbpe_pkg::*;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_wr_en = 1'b0;
    logic [2:0] i_cfg_index = '0;
    logic [7:0] i_cfg_data = '0;
    logic       push = 1'b0;
    logic       full;
    t_item_in   i_item = '0;
    logic       empty;
    logic       pop = 1'b0;
    t_result    o_result;

    int unsigned err_count = 0;
    int unsigned cycle_count = 0;
    bit          hold_pop = 1'b0;
    bit          idle_off = 1'b0;

    localparam int CYCLE_LIMIT = 50000;
    localparam int SCREEN_W = DEF_SCREEN_WIDTH;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic [2:0] CFG_UNUSED  = 3'd7;

    lcd_background_pixel_engine u_dut (.*);

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
        err_count++;
    endtask

    // Behavioral copy of the background engine; a transfer in yields one expected result.
    class lcd_scoreboard;
        logic [7:0]  ctrl, scy, scx, lyc, bgp;
        logic [7:0]  vram [VRAM_BYTES];
        logic [6:0]  ticks;
        logic [1:0]  mode;
        logic [7:0]  ly;
        logic        match;
        logic        phase;
        logic [5:0]  fcol;
        int          col;
        bit          fempty, fneed;
        logic [15:0] plo, phi, pen;
        logic [7:0]  lat_lo, lat_en;
        logic [12:0] row_addr;
        t_result     pending [$];

        function new();
            ctrl = 0; scy = 0; scx = 0; lyc = 0; bgp = 8'd228;
            foreach (vram[i]) vram[i] = 8'h00;
            ticks = 0; mode = MODE_SEARCH; ly = 1; match = 0;
            lat_lo = 0; lat_en = 0; row_addr = 0;
            clear_fetch();
        endfunction

        function void clear_fetch();
            phase = 0; fcol = 0; col = 0; fempty = 1; fneed = 1;
            plo = 0; phi = 0; pen = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [7:0] v);
            case (idx)
                CFG_LCD_CONTROL:  ctrl = v;
                CFG_SCROLL_Y:     scy = v;
                CFG_SCROLL_X:     scx = v;
                CFG_LINE_COMPARE: lyc = v;
                CFG_BG_PALETTE:   bgp = v;
                default: ;
            endcase
        endfunction

        function void finish_line();
            ticks = 0;
            match = (ly == lyc);
            ly = ly + 8'd1;
        endfunction

        function void fetch();
            logic [7:0]  py, tile;
            logic [4:0]  trow, tcol;
            logic [12:0] map, base;
            logic [7:0]  hi;
            py = scy + ly - 8'd1;
            if (!phase) begin
                trow = py[7:3];
                tcol = scx[7:3] + fcol[4:0];
                map = ctrl[3] ? 13'h1C00 : 13'h1800;
                tile = vram[map + {trow, 5'd0} + tcol];
                if (ctrl[4])
                    base = {1'b0, tile, 4'd0};
                else
                    base = 13'h1000 + {{1{tile[7]}}, tile, 4'd0};
                row_addr = base + {py[2:0], 1'b0};
                lat_lo = vram[row_addr];
                lat_en = ctrl[0] ? 8'hFF : 8'h00;
                fcol = fcol + 6'd1;
                phase = 1;
            end else begin
                hi = vram[row_addr + 13'd1];
                if (fempty) begin
                    plo |= {lat_lo, 8'h00}; phi |= {hi, 8'h00}; pen |= {lat_en, 8'h00};
                    fempty = 0;
                end else begin
                    plo |= {8'h00, lat_lo}; phi |= {8'h00, hi}; pen |= {8'h00, lat_en};
                    fneed = 0;
                end
                phase = 0;
            end
        endfunction

        function void step_tick(ref t_result r);
            int n;
            logic [1:0] sh [4];
            logic [1:0] c;
            if (ticks != 7'd127) ticks++;
            case (mode)
                MODE_HBLANK: if (ticks >= LINE_TICKS) begin
                    mode = (ly >= SCREEN_HEIGHT) ? MODE_VBLANK : MODE_SEARCH;
                    finish_line();
                end
                MODE_VBLANK: if (ticks >= LINE_TICKS) begin
                    if (ly >= LAST_LINE) begin
                        r.frame_done = 1; mode = MODE_SEARCH; ly = 0;
                    end
                    finish_line();
                end
                MODE_SEARCH: if (ticks >= SEARCH_TICKS) mode = MODE_XFER;
                default: begin
                    if (!fneed && col < SCREEN_W) begin
                        n = (SCREEN_W - col < 4) ? SCREEN_W - col : 4;
                        sh = '{default: 2'd0};
                        r.pixel_count = 3'(n);
                        r.pixel_x = 8'(col);
                        for (int k = 0; k < n; k++) begin
                            c = {phi[15], plo[15]};
                            sh[k] = pen[15] ? bgp[c*2 +: 2] : 2'd0;
                            plo <<= 1; phi <<= 1; pen <<= 1;
                        end
                        r.shade_a = sh[0]; r.shade_b = sh[1];
                        r.shade_c = sh[2]; r.shade_d = sh[3];
                        col += n;
                    end
                    fetch();
                    if (col >= SCREEN_W) begin
                        clear_fetch();
                        mode = MODE_HBLANK;
                    end
                end
            endcase
        endfunction

        function void note_item(t_item_in it);
            t_result r;
            r = '0;
            case (it.func)
                FUNC_TICK:  step_tick(r);
                FUNC_WRITE: vram[it.vram_address] = it.vram_data;
                FUNC_READ:  r.read_data = vram[it.vram_address];
                default: ;
            endcase
            r.mode = mode; r.line = ly; r.line_match = match;
            pending.push_back(r);
        endfunction

        task check_result(t_result got);
            t_result w;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
                return;
            end
            w = pending.pop_front();
            if (got.mode != w.mode) report_mismatch("mode", got.mode, w.mode);
            if (got.line != w.line) report_mismatch("line", got.line, w.line);
            if (got.line_match != w.line_match)
                report_mismatch("line_match", got.line_match, w.line_match);
            if (got.pixel_count != w.pixel_count)
                report_mismatch("pixel_count", got.pixel_count, w.pixel_count);
            if (got.pixel_x != w.pixel_x) report_mismatch("pixel_x", got.pixel_x, w.pixel_x);
            if (got.shade_a != w.shade_a) report_mismatch("shade_a", got.shade_a, w.shade_a);
            if (got.shade_b != w.shade_b) report_mismatch("shade_b", got.shade_b, w.shade_b);
            if (got.shade_c != w.shade_c) report_mismatch("shade_c", got.shade_c, w.shade_c);
            if (got.shade_d != w.shade_d) report_mismatch("shade_d", got.shade_d, w.shade_d);
            if (got.frame_done != w.frame_done)
                report_mismatch("frame_done", got.frame_done, w.frame_done);
            if (got.read_data != w.read_data)
                report_mismatch("read_data", got.read_data, w.read_data);
        endtask
    endclass

    lcd_scoreboard sb = new();

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        if (i_rst_n && push && !full) sb.note_item(i_item);
        if (i_rst_n && pop && !empty) sb.check_result(o_result);
    end

    // Result side: random stall bursts, plus a long hold-off on request.
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_pop) begin
                pop <= 1'b0;
                for (int k = 0; k < 60; k++) @(negedge i_clk);
                hold_pop = 1'b0;
            end else if (!idle_off && $urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 8);
                pop <= 1'b0;
                for (int k = 1; k < n; k++) @(negedge i_clk);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Tile indices that the map may hold; their rows exist in both data areas.
    function automatic logic [7:0] pick_tile();
        case ($urandom_range(0, 2))
            0:       return 8'h00;
            1:       return 8'h01;
            default: return 8'hFF;
        endcase
    endfunction

    // Any address that the init pass has written.
    function automatic logic [12:0] pick_addr();
        case ($urandom_range(0, 4))
            0:       return 13'h1800 + 13'($urandom_range(0, 31));
            1:       return 13'h1C00 + 13'($urandom_range(0, 31));
            2:       return 13'($urandom_range(0, 31));
            3:       return 13'h1000 + 13'($urandom_range(0, 31));
            default: return 13'h0FF0 + 13'($urandom_range(0, 15));
        endcase
    endfunction

    // Map entries only ever hold known tiles, tile rows take any byte.
    function automatic logic [7:0] pick_data(input logic [12:0] a);
        return (a[12:11] == 2'b11) ? pick_tile() : 8'($urandom);
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] v);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1; i_cfg_index <= idx; i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    // Stops offering, waits for the scoreboard to drain, then waits out a margin.
    task automatic drain();
        push <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    // Offers one item; caller is at a falling edge, push stays high on return.
    task automatic send_item(input logic [1:0] f, input logic [12:0] a, input logic [7:0] d);
        if (!idle_off && $urandom_range(0, 11) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        push <= 1'b1;
        i_item <= '{func: f, vram_address: a, vram_data: d};
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_ticks(input int n);
        for (int k = 0; k < n; k++) send_item(FUNC_TICK, 13'($urandom), 8'($urandom));
    endtask

    // Map row 0 of both maps plus the rows of tiles 0x00, 0x01 and 0xFF in both data areas.
    task automatic init_vram();
        for (int m = 0; m < 32; m++) begin
            send_item(FUNC_WRITE, 13'h1800 + 13'(m), pick_tile());
            send_item(FUNC_WRITE, 13'h1C00 + 13'(m), pick_tile());
            send_item(FUNC_WRITE, 13'(m), 8'($urandom));
            send_item(FUNC_WRITE, 13'h1000 + 13'(m), 8'($urandom));
        end
        for (int m = 0; m < 16; m++) send_item(FUNC_WRITE, 13'h0FF0 + 13'(m), 8'($urandom));
    endtask

    initial begin
        logic [12:0] a;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        init_vram();
        // Directed: field extremes, writes and reads, the unused func code
        send_item(FUNC_WRITE, 13'h0000, 8'h00);
        send_item(FUNC_WRITE, 13'h1FFF, 8'hFF);
        send_item(FUNC_READ, 13'h0000, 8'hFF);
        send_item(FUNC_READ, 13'h1FFF, 8'h00);
        send_item(FUNC_UNUSED, 13'h1FFF, 8'hFF);

        // Scroll Y stays small so the first lines fetch from map row 0
        drain();
        write_reg(CFG_LCD_CONTROL, 8'h00);
        write_reg(CFG_SCROLL_Y, 8'h04);
        write_reg(CFG_SCROLL_X, 8'hFF);
        write_reg(CFG_LINE_COMPARE, 8'd2);
        write_reg(CFG_BG_PALETTE, 8'h1B);
        write_reg(CFG_UNUSED, 8'hA5);

        // Long receiver hold-off while items keep coming
        hold_pop = 1'b1;
        send_ticks(40);

        for (int ph = 0; ph < 3; ph++) begin
            drain();
            write_reg(CFG_LCD_CONTROL, (ph == 2) ? 8'hFF : 8'($urandom));
            write_reg(CFG_SCROLL_Y, 8'($urandom_range(0, 4)));
            write_reg(CFG_SCROLL_X, (ph == 0) ? 8'h00 : 8'($urandom));
            write_reg(CFG_LINE_COMPARE, 8'($urandom_range(0, 4)));
            write_reg(CFG_BG_PALETTE, (ph == 1) ? 8'hFF : 8'($urandom));
            if (ph == 2) idle_off = 1'b1;
            for (int k = 0; k < 90; k++) begin
                case ($urandom_range(0, 9))
                    0: begin
                        a = pick_addr();
                        send_item(FUNC_WRITE, a, pick_data(a));
                    end
                    1: send_item(FUNC_READ, pick_addr(), 8'($urandom));
                    2: send_item(FUNC_UNUSED, 13'($urandom), 8'($urandom));
                    default: send_ticks(1);
                endcase
            end
        end

        drain();
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
